// ----- design/dns_query_encoder_top_assert.svh -----
// Assertion macros for the DNS query encoder, empty when compiled for synthesis.
`ifndef DNS_QUERY_ENCODER_TOP_ASSERT_SVH
`define DNS_QUERY_ENCODER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Property checked on each rising clock edge, disabled while reset is held.
`define DQE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked on each rising clock edge, also during reset.
`define DQE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define DQE_ASSERT(lbl, clk, rstn, prop, msg)
`define DQE_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- design/dqe_pkg.sv -----
// Shared types and constants of the DNS query encoder.
`default_nettype none

package dqe_pkg;

  // Label buffer geometry: 63 characters, indexed by six bits.
  localparam int unsigned STORE_DEPTH = 63;
  localparam int unsigned IDX_W       = 6;

  localparam int unsigned HEADER_BYTES = 12;
  localparam int unsigned TAIL_BYTES   = 5;

  localparam logic [7:0]  DOT_CHAR = 8'h2E;
  localparam logic [15:0] RD_FLAG  = 16'h0100;

  // Input item kinds as carried on the slave-side tuser.
  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_NAME_END = 2'd1,
    KIND_TAIL     = 2'd2,
    KIND_HEADER   = 2'd3
  } kind_e;

  // Register indexes of the configuration port.
  localparam logic REG_QUERY_ID  = 1'b0;
  localparam logic REG_RECURSION = 1'b1;

  typedef logic [IDX_W-1:0] idx_t;

endpackage

`default_nettype wire

// ----- design/dqe_label_ram.sv -----
// Label character buffer: one write port, one registered read port.
`default_nettype none

module dqe_label_ram (
  input  logic              clk_i,
  input  logic              we_i,
  input  dqe_pkg::idx_t     waddr_i,
  input  logic [7:0]        wdata_i,
  input  dqe_pkg::idx_t     raddr_i,
  output logic [7:0]        rdata_o
);
  import dqe_pkg::*;

  logic [7:0] mem [STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- design/dns_query_encoder_top.sv -----
// Top level of the DNS query encoder: sequencer, byte selector and registers.
//
//   Channel     Direction  Handshake                 Content
//   s_axis      in         tvalid/tready             tuser: kind; tdata: char, type, class
//   m_axis      out        tvalid/tready             tdata: byte; tuser: header, overflow
//   APB         in/out     psel, penable, pready     query_id at 0x0, recursion flag at 0x4
//
// A name character other than a dot is accepted and emits nothing.
// Any other item is accepted and then emits one output byte per cycle while the
// master side does not stall: label length plus one bytes for a label flush,
// five for a question tail and twelve for a header request. The rate is set by
// the single byte selector, which produces one byte a cycle.
// Reset is asynchronous and active low; the label buffer itself is not cleared,
// as only characters written since the last flush are ever read.
// A stall on the master side holds the sequencer; no new item is accepted until
// the last byte of the current one has entered the output register.
`default_nettype none

module dns_query_encoder_top #(
  parameter int unsigned LABEL_MAX = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] char_byte, [23:8] question type, [39:24] question class
  input  logic [39:0] s_axis_tdata_i,
  // [1:0] kind
  input  logic [1:0]  s_axis_tuser_i,

  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [7:0] out_byte
  output logic [7:0]  m_axis_tdata_o,
  // [0] is_header, [1] label_overflow
  output logic [1:0]  m_axis_tuser_o,
  output logic        m_axis_tlast_o,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import dqe_pkg::*;

  // Characters kept per label: the parameter, capped by the buffer depth.
  localparam int unsigned LimitInt = (LABEL_MAX < STORE_DEPTH) ? LABEL_MAX : STORE_DEPTH;
  localparam idx_t LabelLimit = IDX_W'(LimitInt);
  localparam idx_t TailLast   = IDX_W'(TAIL_BYTES - 1);
  localparam idx_t HdrLast    = IDX_W'(HEADER_BYTES - 1);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  typedef enum logic [1:0] {
    MODE_LABEL,
    MODE_TAIL,
    MODE_HEADER
  } mode_e;

  state_e      state_q, state_d;
  mode_e       mode_q, mode_d;
  idx_t        step_q, step_d;
  idx_t        last_q, last_d;
  idx_t        flush_len_q, flush_len_d;
  logic        flush_ovf_q, flush_ovf_d;
  logic [15:0] rtype_q, rtype_d;
  logic [15:0] rclass_q, rclass_d;

  idx_t        label_len_q, label_len_d;
  logic        ovf_seen_q, ovf_seen_d;
  logic [15:0] qcount_q, qcount_d;

  logic [15:0] query_id_q, query_id_d;
  logic        recursion_q, recursion_d;

  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_hdr_q, out_hdr_d;
  logic        out_last_q, out_last_d;
  logic        out_ovf_q, out_ovf_d;

  logic        s_fire;
  logic        cfg_wr;
  logic        emit;
  logic        ram_we;
  idx_t        ram_raddr;
  logic [7:0]  ram_rdata;

  logic [7:0]  sel_byte;
  logic        sel_hdr;
  logic        sel_ovf;
  logic [15:0] flags;

  logic [1:0]  in_kind;
  logic [7:0]  in_char;

  assign in_kind = s_axis_tuser_i;
  assign in_char = s_axis_tdata_i[7:0];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // During a run, a byte moves into the output register whenever it is empty or being drained.
  assign emit = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  // Characters are written only while idle, so a write never meets a flush read.
  assign ram_we = s_fire && (in_kind == KIND_CHAR) && (in_char != DOT_CHAR) &&
                  (label_len_q < LabelLimit);

  // The read address follows the next step value: step k shows character k-1.
  assign ram_raddr = (step_d == '0) ? '0 : step_d - idx_t'(1);

  dqe_label_ram u_label_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (label_len_q),
    .wdata_i (in_char),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign flags = recursion_q ? RD_FLAG : 16'h0000;

  // Byte selector shared by all three kinds of output run.
  always_comb begin
    sel_byte = 8'h00;
    sel_hdr  = 1'b0;
    sel_ovf  = 1'b0;
    case (mode_q)
      MODE_LABEL: begin
        sel_ovf  = flush_ovf_q;
        sel_byte = (step_q == '0) ? {2'b00, flush_len_q} : ram_rdata;
      end
      MODE_TAIL: begin
        case (step_q[2:0])
          3'd1:    sel_byte = rtype_q[15:8];
          3'd2:    sel_byte = rtype_q[7:0];
          3'd3:    sel_byte = rclass_q[15:8];
          3'd4:    sel_byte = rclass_q[7:0];
          default: sel_byte = 8'h00;
        endcase
      end
      MODE_HEADER: begin
        sel_hdr = 1'b1;
        case (step_q[3:0])
          4'd0:    sel_byte = query_id_q[15:8];
          4'd1:    sel_byte = query_id_q[7:0];
          4'd2:    sel_byte = flags[15:8];
          4'd3:    sel_byte = flags[7:0];
          4'd4:    sel_byte = qcount_q[15:8];
          4'd5:    sel_byte = qcount_q[7:0];
          default: sel_byte = 8'h00;
        endcase
      end
      default: begin
        sel_byte = 8'h00;
      end
    endcase
  end

  // Configuration registers; the low address bits are ignored.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_RECURSION) ? {31'b0, recursion_q} : {16'b0, query_id_q};

  always_comb begin
    query_id_d  = query_id_q;
    recursion_d = recursion_q;
    if (cfg_wr) begin
      if (paddr[2] == REG_QUERY_ID) begin
        query_id_d = pwdata[15:0];
      end else begin
        recursion_d = pwdata[0];
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    step_d      = step_q;
    last_d      = last_q;
    flush_len_d = flush_len_q;
    flush_ovf_d = flush_ovf_q;
    rtype_d     = rtype_q;
    rclass_d    = rclass_q;
    label_len_d = label_len_q;
    ovf_seen_d  = ovf_seen_q;
    qcount_d    = qcount_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_byte_d  = out_byte_q;
    out_hdr_d   = out_hdr_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    if (s_fire) begin
      step_d = '0;
      case (in_kind)
        KIND_CHAR, KIND_NAME_END: begin
          if ((in_kind == KIND_NAME_END) || (in_char == DOT_CHAR)) begin
            // The label's state is handed to the run and cleared at once.
            state_d     = ST_EMIT;
            mode_d      = MODE_LABEL;
            flush_len_d = label_len_q;
            flush_ovf_d = ovf_seen_q;
            last_d      = label_len_q;
            label_len_d = '0;
            ovf_seen_d  = 1'b0;
          end else if (label_len_q < LabelLimit) begin
            label_len_d = label_len_q + idx_t'(1);
          end else begin
            ovf_seen_d = 1'b1;
          end
        end
        KIND_TAIL: begin
          state_d  = ST_EMIT;
          mode_d   = MODE_TAIL;
          last_d   = TailLast;
          rtype_d  = s_axis_tdata_i[23:8];
          rclass_d = s_axis_tdata_i[39:24];
          qcount_d = qcount_q + 16'd1;
        end
        KIND_HEADER: begin
          state_d = ST_EMIT;
          mode_d  = MODE_HEADER;
          last_d  = HdrLast;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end else if (emit) begin
      out_valid_d = 1'b1;
      out_byte_d  = sel_byte;
      out_hdr_d   = sel_hdr;
      out_ovf_d   = sel_ovf;
      out_last_d  = (step_q == last_q);
      if (step_q == last_q) begin
        state_d = ST_IDLE;
        step_d  = '0;
      end else begin
        step_d = step_q + idx_t'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_LABEL;
      step_q      <= '0;
      last_q      <= '0;
      flush_len_q <= '0;
      flush_ovf_q <= 1'b0;
      rtype_q     <= '0;
      rclass_q    <= '0;
      label_len_q <= '0;
      ovf_seen_q  <= 1'b0;
      qcount_q    <= '0;
      query_id_q  <= 16'd1;
      recursion_q <= 1'b0;
      out_valid_q <= 1'b0;
      out_byte_q  <= '0;
      out_hdr_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      step_q      <= step_d;
      last_q      <= last_d;
      flush_len_q <= flush_len_d;
      flush_ovf_q <= flush_ovf_d;
      rtype_q     <= rtype_d;
      rclass_q    <= rclass_d;
      label_len_q <= label_len_d;
      ovf_seen_q  <= ovf_seen_d;
      qcount_q    <= qcount_d;
      query_id_q  <= query_id_d;
      recursion_q <= recursion_d;
      out_valid_q <= out_valid_d;
      out_byte_q  <= out_byte_d;
      out_hdr_q   <= out_hdr_d;
      out_last_q  <= out_last_d;
      out_ovf_q   <= out_ovf_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tuser_o  = {out_ovf_q, out_hdr_q};
  assign m_axis_tlast_o  = out_last_q;

`include "dns_query_encoder_top_assert.svh"

  // A stalled output register must freeze the run position.
  `DQE_ASSERT(a_step_hold, clk_i, rst_ni, (state_q == ST_EMIT && out_valid_q && !m_axis_tready_i) |=> $stable(step_q), "run position moved while the output was stalled")

  // The run never steps past its final byte.
  `DQE_ASSERT(a_step_bound, clk_i, rst_ni, (state_q == ST_EMIT) |-> (step_q <= last_q), "run position beyond the final byte")

  // The buffered label never exceeds the kept-character limit; the counter is
  // only defined once reset has been seen.
  `DQE_ASSERT_ALWAYS(a_label_bound, clk_i, !rst_ni || (label_len_q <= LabelLimit), "label length beyond the limit")

endmodule

`default_nettype wire

// ----- sim/dns_query_encoder_checker.sv -----
// Checker for the DNS query encoder: predicts the encoded byte stream and compares it.
module dns_query_encoder_checker #(
  parameter int unsigned LABEL_MAX = 63
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  input  logic        s_axis_tready_i,
  input  logic [39:0] s_axis_tdata_i,
  input  logic [1:0]  s_axis_tuser_i,
  input  logic        m_axis_tvalid_i,
  input  logic        m_axis_tready_i,
  input  logic [7:0]  m_axis_tdata_i,
  input  logic [1:0]  m_axis_tuser_i,
  input  logic        m_axis_tlast_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          bytes_seen_o
);
  import dqe_pkg::*;

  localparam int unsigned LABEL_KEEP = (LABEL_MAX < STORE_DEPTH) ? LABEL_MAX : STORE_DEPTH;

  typedef struct packed {
    logic [7:0] data;
    logic       is_header;
    logic       run_last;
    logic       label_overflow;
  } query_byte_t;

  query_byte_t query_byte_q[$];
  logic [7:0]  label_buf[STORE_DEPTH];
  int unsigned label_len = 0;
  logic        overflow_seen = 1'b0;
  logic [15:0] question_count = '0;
  logic [15:0] query_id = 16'd1;
  logic        recursion_desired = 1'b0;
  int          fail_count = 0;
  int          bytes_seen = 0;

  task automatic push_byte(input logic [7:0] data, input logic hdr, input logic ovf);
    query_byte_t entry;
    entry = '{data, hdr, 1'b0, ovf};
    query_byte_q.insert(query_byte_q.size(), entry);
  endtask

  task automatic flush_label();
    push_byte(8'(label_len), 1'b0, overflow_seen);
    for (int i = 0; i < label_len; i++) push_byte(label_buf[i], 1'b0, overflow_seen);
    label_len     = 0;
    overflow_seen = 1'b0;
  endtask

  // Works out the bytes that one accepted item produces and queues them.
  task automatic encode_query_item(input kind_e kind, input logic [7:0] ch,
                                   input logic [15:0] rtype, input logic [15:0] rclass);
    int          queued_before;
    logic [15:0] flags;
    query_byte_t final_byte;
    queued_before = query_byte_q.size();
    case (kind)
      KIND_CHAR: begin
        if (ch == DOT_CHAR) begin
          flush_label();
        end else if (label_len < LABEL_KEEP) begin
          label_buf[label_len] = ch;
          label_len++;
        end else begin
          overflow_seen = 1'b1;
        end
      end
      KIND_NAME_END: flush_label();
      KIND_TAIL: begin
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(rtype[15:8], 1'b0, 1'b0);
        push_byte(rtype[7:0], 1'b0, 1'b0);
        push_byte(rclass[15:8], 1'b0, 1'b0);
        push_byte(rclass[7:0], 1'b0, 1'b0);
        question_count++;
      end
      default: begin
        flags = recursion_desired ? RD_FLAG : 16'h0000;
        push_byte(query_id[15:8], 1'b1, 1'b0);
        push_byte(query_id[7:0], 1'b1, 1'b0);
        push_byte(flags[15:8], 1'b1, 1'b0);
        push_byte(flags[7:0], 1'b1, 1'b0);
        push_byte(question_count[15:8], 1'b1, 1'b0);
        push_byte(question_count[7:0], 1'b1, 1'b0);
        repeat (HEADER_BYTES - 6) push_byte(8'h00, 1'b1, 1'b0);
      end
    endcase
    if (query_byte_q.size() > queued_before) begin
      final_byte          = query_byte_q[query_byte_q.size() - 1];
      final_byte.run_last = 1'b1;
      query_byte_q[query_byte_q.size() - 1] = final_byte;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_byte(input query_byte_t got);
    query_byte_t want;
    bytes_seen++;
    if (query_byte_q.size() == 0) begin
      $error("out_byte: no byte expected, got 0x%0h", got.data);
      fail_count++;
    end else begin
      want = query_byte_q.pop_front();
      compare_field("out_byte", 32'(want.data), 32'(got.data));
      compare_field("is_header", 32'(want.is_header), 32'(got.is_header));
      compare_field("run_last", 32'(want.run_last), 32'(got.run_last));
      compare_field("label_overflow", 32'(want.label_overflow), 32'(got.label_overflow));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      query_byte_q.delete();
      label_len         = 0;
      overflow_seen     = 1'b0;
      question_count    = '0;
      query_id          = 16'd1;
      recursion_desired = 1'b0;
    end else begin
      // Output first: a byte leaving at this edge never belongs to an item taken at it.
      if (m_axis_tvalid_i && m_axis_tready_i)
        check_byte('{m_axis_tdata_i, m_axis_tuser_i[0], m_axis_tlast_i, m_axis_tuser_i[1]});
      if (s_axis_tvalid_i && s_axis_tready_i)
        encode_query_item(kind_e'(s_axis_tuser_i), s_axis_tdata_i[7:0],
                          s_axis_tdata_i[23:8], s_axis_tdata_i[39:24]);
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == {REG_QUERY_ID, 2'b00}) query_id = pwdata[15:0];
          else if (paddr == {REG_RECURSION, 2'b00}) recursion_desired = pwdata[0];
        end else if (paddr == {REG_QUERY_ID, 2'b00}) begin
          compare_field("prdata query_id", {16'h0000, query_id}, prdata);
        end else if (paddr == {REG_RECURSION, 2'b00}) begin
          compare_field("prdata recursion_desired", {31'd0, recursion_desired}, prdata);
        end
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= query_byte_q.size();
    bytes_seen_o <= bytes_seen;
  end

endmodule

// ----- sim/dns_query_encoder_top_test.sv -----
// Testbench top for the DNS query encoder: clock, reset, stimulus and verdict.
module dns_query_encoder_top_test;
  import dqe_pkg::*;

  // The label limit under test; the checker is built with the same value.
  localparam int unsigned LABEL_MAX = 63;

  // Generous bound on the whole run. About 230 items, each emitting at most 64
  // bytes with every byte behind the longest sink stall, stay well within it.
  localparam int CYCLE_LIMIT = 6_000_000;

  logic        clk_i   = 1'b0;
  logic        rst_ni  = 1'b0;

  logic        s_valid = 1'b0;
  logic [39:0] s_data  = '0;
  logic [1:0]  s_kind  = '0;
  logic        m_ready = 1'b0;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;

  wire         s_ready;
  wire         m_valid;
  wire  [7:0]  m_data;
  wire  [1:0]  m_user;
  wire         m_last;
  wire  [31:0] prdata;
  wire         pready;

  int          fail_count;
  int          pending_bytes;
  int          bytes_seen;

  int          cycle_count = 0;
  int          items_sent  = 0;
  logic [15:0] tails_sent  = '0;
  int          stall_left  = 0;
  // When set, neither side starts an idle stretch: for stretches of back-to-back traffic.
  logic        quiet       = 1'b0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  dns_query_encoder_top #(
    .LABEL_MAX(LABEL_MAX)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  dns_query_encoder_checker #(
    .LABEL_MAX(LABEL_MAX)
  ) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_i (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_kind),
    .m_axis_tvalid_i (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_i  (m_data),
    .m_axis_tuser_i  (m_user),
    .m_axis_tlast_i  (m_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count_o    (fail_count),
    .pending_o       (pending_bytes),
    .bytes_seen_o    (bytes_seen)
  );

  // Length of an idle stretch: mostly none or short, now and then a long one.
  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 45) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // The byte sink stalls at random unless a quiet stretch is running.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_ready    <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      stall_left <= idle_cycles();
      m_ready    <= 1'b0;
    end else begin
      m_ready <= 1'b1;
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d bytes still due.",
               cycle_count, pending_bytes);
      $display("dns_query_encoder_top test failed");
      $finish;
    end
  end

  // Offers one item and returns at the edge that accepts it. Valid is left
  // high, so that a following item with no gap simply replaces the data; any
  // pause lowers it first, in the step of the accepting edge.
  task automatic send_item(input kind_e kind, input logic [7:0] ch,
                           input logic [15:0] rtype, input logic [15:0] rclass);
    int gap;
    gap = quiet ? 0 : idle_cycles();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_kind  <= kind;
    s_data  <= {rclass, rtype, ch};
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    items_sent++;
    if (kind == KIND_TAIL) tails_sent++;
  endtask

  // Holds the sender back until every predicted byte has left the block,
  // then allows a few more cycles for an item that produces no bytes.
  task automatic settle_queue();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_bytes != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // One register access: the setup phase, then the access phase until pready.
  task automatic reg_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes both registers and reads them back; only called while idle.
  task automatic set_registers(input logic [15:0] id, input logic rd);
    reg_access(1'b1, {REG_QUERY_ID, 2'b00}, {16'h0000, id});
    reg_access(1'b1, {REG_RECURSION, 2'b00}, {31'd0, rd});
    reg_access(1'b0, {REG_QUERY_ID, 2'b00}, '0);
    reg_access(1'b0, {REG_RECURSION, 2'b00}, '0);
  endtask

  // A well-formed question with random content: sometimes a header first,
  // then a few labels each closed by a dot or a name end, then the tail.
  // A little noise (any kind, any field values) is mixed in.
  task automatic send_query(input bit force_long);
    int         labels;
    int         len;
    logic [7:0] ch;
    quiet <= ($urandom_range(0, 5) == 0);
    if ($urandom_range(0, 3) == 0)
      send_item(KIND_HEADER, 8'($urandom), 16'($urandom), 16'($urandom));
    labels = force_long ? $urandom_range(1, 3) : $urandom_range(0, 3);
    for (int lbl = 0; lbl < labels; lbl++) begin
      // Long labels straddle the 63-character limit so that some are truncated.
      if ((force_long && lbl == 0) || $urandom_range(0, 11) == 0)
        len = $urandom_range(61, 70);
      else
        len = $urandom_range(0, 8);
      repeat (len) begin
        ch = 8'($urandom);
        if (ch == DOT_CHAR) ch = ch ^ 8'h01;
        send_item(KIND_CHAR, ch, 16'($urandom), 16'($urandom));
      end
      if ($urandom_range(0, 1) == 0)
        send_item(KIND_CHAR, DOT_CHAR, 16'($urandom), 16'($urandom));
      else
        send_item(KIND_NAME_END, 8'($urandom), 16'($urandom), 16'($urandom));
    end
    if ($urandom_range(0, 4) == 0)
      send_item(kind_e'($urandom_range(0, 3)), 8'($urandom), 16'($urandom), 16'($urandom));
    send_item(KIND_TAIL, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // Random traffic of about the given number of items, with a long label in the first query.
  task automatic random_queries(input int count);
    int target;
    target = items_sent + count;
    send_query(1'b1);
    while (items_sent < target) send_query(1'b0);
    quiet <= 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The registers must read back their reset values.
    reg_access(1'b0, {REG_QUERY_ID, 2'b00}, '0);
    reg_access(1'b0, {REG_RECURSION, 2'b00}, '0);

    // Directed part. Header with the reset id and a zero question count.
    send_item(KIND_HEADER, 8'h00, 16'h0000, 16'h0000);
    // Two characters are only buffered; the dot emits the length and both.
    send_item(KIND_CHAR, "w", 16'hFFFF, 16'hFFFF);
    send_item(KIND_CHAR, "w", 16'h0000, 16'h0000);
    send_item(KIND_CHAR, DOT_CHAR, 16'hFFFF, 16'h0000);
    // Empty labels, from a dot and from a name end, give a single zero.
    send_item(KIND_CHAR, DOT_CHAR, 16'h0000, 16'hFFFF);
    send_item(KIND_NAME_END, 8'hFF, 16'hFFFF, 16'hFFFF);
    // Extreme character values inside a label.
    send_item(KIND_CHAR, 8'h00, 16'h0000, 16'h0000);
    send_item(KIND_CHAR, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_item(KIND_NAME_END, 8'h00, 16'h0000, 16'h0000);
    // Tails with extreme type and class codes.
    send_item(KIND_TAIL, 8'hFF, 16'hFFFF, 16'h0000);
    send_item(KIND_TAIL, 8'h00, 16'h0000, 16'hFFFF);
    // A tail leaves a pending label alone; the name end flushes it later.
    send_item(KIND_CHAR, "x", 16'h1234, 16'h5678);
    send_item(KIND_TAIL, 8'h2E, 16'h00FF, 16'hFF00);
    send_item(KIND_NAME_END, 8'hAA, 16'h5555, 16'hAAAA);
    // Header after three questions.
    send_item(KIND_HEADER, 8'h55, 16'hAAAA, 16'h5555);

    // Zero id with recursion desired; the sender waits for the block to drain.
    settle_queue();
    set_registers(16'h0000, 1'b1);
    send_item(KIND_HEADER, 8'h00, 16'h0000, 16'h0000);
    random_queries(70);

    // Largest id, recursion off.
    settle_queue();
    set_registers(16'hFFFF, 1'b0);
    random_queries(60);

    // Random register values for the last random phase.
    settle_queue();
    set_registers(16'($urandom), 1'($urandom));
    random_queries(60);

    // Drain, then watch a while longer for any stray byte.
    settle_queue();
    repeat (80) @(posedge clk_i);

    $display("Covered %0d items (%0d question tails) and %0d bytes",
             items_sent, tails_sent, bytes_seen);
    $display("in %0d cycles across four register settings; %0d mismatches.",
             cycle_count, fail_count);
    if (fail_count == 0) begin
      $display("dns_query_encoder_top test passed");
    end else begin
      $display("dns_query_encoder_top test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/dqe_pkg.sv
design/dqe_label_ram.sv
design/dns_query_encoder_top.sv
sim/dns_query_encoder_checker.sv
sim/dns_query_encoder_top_test.sv
